// ----- rtl/core/swa_pkg.sv -----
// ----------------------------------------------------------------------------
// swa_pkg
// Shared types, widths and constants for the softmax/argmax classifier output.
// ----------------------------------------------------------------------------
package swa_pkg;

  // Field widths
  localparam int LOGIT_W = 13;
  localparam int PROB_W  = 16;
  localparam int IDX_W   = 10;

  // Default vector length
  localparam int MAX_CLASSES = 1024;

  // Datapath widths
  localparam int SUM_W   = 50;   // saturating exp accumulator
  localparam int E_W     = 41;   // exp value, Q.16, up to about 2^39.1
  localparam int ACC_W   = 45;   // serial multiplier accumulator / multiplicand
  localparam int MPL_W   = 25;   // serial multiplier operand
  localparam int MANT_W  = 34;   // 2^f mantissa, Q.32
  localparam int USH_W   = 6;    // integer part of the biased exponent
  localparam int FRAC_W  = 20;   // residual fraction r
  localparam int PP_W    = 15;   // (p*p) >> 25
  localparam int M_W     = 25;   // 2^r in Q.24
  localparam int TAB_W   = 17;   // 2^(k/16) in Q.16

  // Division: one quotient bit per step
  localparam int DIV_STEPS = 16;
  localparam int DIV_CNT_W = 4;

  // Arithmetic constants
  localparam logic [16:0] LOG2E_Q16 = 17'd94548;
  localparam logic [23:0] LN2_Q24   = 24'd11629080;
  // bias of 32 in Q.24 so that the scaled logit is always positive
  localparam logic [29:0] EXP_BIAS  = 30'h2000_0000;
  // right shift that maps the biased exponent to the output scale
  localparam logic [USH_W-1:0] SHIFT_BASE = 6'd55;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_Y,
    S_MUL_P,
    S_MUL_PP,
    S_MUL_MANT,
    S_APPLY,
    S_DIV,
    S_FINISH
  } state_t;

  // 2^(k/16) in Q.16, rounded
  function automatic logic [TAB_W-1:0] pow2_frac(input logic [3:0] k);
    logic [TAB_W-1:0] v;
    case (k)
      4'd0:    v = 17'd65536;
      4'd1:    v = 17'd68438;
      4'd2:    v = 17'd71468;
      4'd3:    v = 17'd74632;
      4'd4:    v = 17'd77936;
      4'd5:    v = 17'd81386;
      4'd6:    v = 17'd84990;
      4'd7:    v = 17'd88752;
      4'd8:    v = 17'd92682;
      4'd9:    v = 17'd96785;
      4'd10:   v = 17'd101070;
      4'd11:   v = 17'd105545;
      4'd12:   v = 17'd110218;
      4'd13:   v = 17'd115098;
      4'd14:   v = 17'd120194;
      4'd15:   v = 17'd125515;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/softmax_with_argmax.sv -----
// ----------------------------------------------------------------------------
// softmax_with_argmax
// Two-pass fixed-point softmax over a logit vector, with running argmax.
// ----------------------------------------------------------------------------
// Usage:
//   Send the logit vector twice on the s_axis channel. Beats with tuser = 0
//   (accumulate pass) add exp(logit) into a 50-bit saturating sum and produce
//   nothing. Beats with tuser = 1 (normalize pass) each produce one m_axis beat
//   with exp(logit)/sum in Q0.16, the class index, and the first index of the
//   largest probability so far. tlast closes a pass; the end of the normalize
//   pass clears all state for the next vector.
// Timing:
//   One beat is processed at a time. A shared bit-serial shift-add multiplier
//   runs four products (log2e scaling, r*ln2, p*p, table*series); each shifts
//   through its multiplier until the bits left are zero. A normalize beat adds a
//   restoring divider, one quotient bit per cycle, unless exp is not below the
//   sum, in which case the probability saturates.
// Reset:
//   rst clears the sum, the position count, the argmax and the output valid.
// Stall:
//   The result sits in an output register; the next beat is taken while it
//   waits, and the block holds in its final step only if a second result is
//   ready before the first one has been taken.
// ----------------------------------------------------------------------------
module softmax_with_argmax #(
  parameter int MAX_CLASSES = swa_pkg::MAX_CLASSES
) (
  input  logic        clk,
  input  logic        rst,
  // input beat
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [12:0] logit
  input  logic        s_axis_tuser,   // [0] kind
  input  logic        s_axis_tlast,   // last
  // result beat
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] probability, [25:16] class_index, [35:26] best_index,
  // [51:36] best_probability
  output logic [55:0] m_axis_tdata,
  output logic        m_axis_tlast    // is_last
);

  localparam int LOGIT_W = swa_pkg::LOGIT_W;
  localparam int PROB_W  = swa_pkg::PROB_W;
  localparam int IDX_W   = swa_pkg::IDX_W;
  localparam int SUM_W   = swa_pkg::SUM_W;
  localparam int E_W     = swa_pkg::E_W;
  localparam int ACC_W   = swa_pkg::ACC_W;
  localparam int MPL_W   = swa_pkg::MPL_W;
  localparam int MANT_W  = swa_pkg::MANT_W;
  localparam int USH_W   = swa_pkg::USH_W;
  localparam int FRAC_W  = swa_pkg::FRAC_W;
  localparam int M_W     = swa_pkg::M_W;
  localparam int DIV_CNT_W = swa_pkg::DIV_CNT_W;
  localparam int CNT_W   = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_CLASSES - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(swa_pkg::DIV_STEPS - 1);

  // Control state
  swa_pkg::state_t state, state_next;
  logic [SUM_W-1:0]  exp_sum;
  logic [CNT_W-1:0]  count;
  logic [PROB_W-1:0] top_prob;
  logic [CNT_W-1:0]  top_idx;
  logic              out_valid;

  // Item registers
  logic              kind_q;
  logic              last_q;
  logic [CNT_W-1:0]  idx_q;

  // Serial multiplier
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  mcand;
  logic [MPL_W-1:0]  mplier;

  // Exp intermediates
  logic [USH_W-1:0]  ushift;
  logic [3:0]        frac_k;
  logic [FRAC_W-1:0] p_val;
  logic [E_W-1:0]    e_val;

  // Divider
  logic [SUM_W-1:0]     rem;
  logic [PROB_W-1:0]    quot;
  logic [DIV_CNT_W-1:0] div_cnt;

  // Output register
  logic [PROB_W-1:0] out_prob;
  logic [IDX_W-1:0]  out_idx;
  logic              out_last;
  logic [IDX_W-1:0]  out_best_idx;
  logic [PROB_W-1:0] out_best_prob;

  // Handshake and strobes
  logic in_fire;
  logic out_fire;
  logic out_free;
  logic finish_fire;
  logic sum_fire;
  logic mul_done;

  // Combinational datapath values
  logic [29:0]       u_val;
  logic [M_W-1:0]    m_val;
  logic [MANT_W-1:0] mant;
  logic [E_W-1:0]    e_wide;
  logic [E_W-1:0]    e_shift;
  logic [E_W-1:0]    e_calc;
  logic [USH_W-1:0]  e_sh;
  logic [SUM_W:0]    sum_add;
  logic [SUM_W-1:0]  sum_sat;
  logic              e_ge_sum;
  logic [SUM_W:0]    rem2;
  logic              rem_ge;
  logic [SUM_W:0]    rem_sub;
  logic [CNT_W-1:0]  count_adv;
  logic              better;
  logic [PROB_W-1:0] best_prob_sel;
  logic [CNT_W-1:0]  best_idx_sel;

  // Handshakes
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign mul_done = (mplier == '0);

  // Biased scaled logit: y + 32 in Q.24
  assign u_val = acc[29:0] + swa_pkg::EXP_BIAS;

  // Second-order series for 2^r
  assign m_val = (M_W'(1) << 24) + M_W'(p_val) + M_W'(acc[39:25]);

  // Scale mantissa by 2^(n-16)
  assign mant    = acc[41:8];
  assign e_wide  = {mant, 7'b0};
  assign e_sh    = swa_pkg::SHIFT_BASE - ushift;
  assign e_shift = e_wide >> e_sh;
  assign e_calc  = (e_shift == '0) ? E_W'(1) : e_shift;

  // Saturating accumulate
  assign sum_add = {1'b0, exp_sum} + (SUM_W + 1)'(e_val);
  assign sum_sat = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign e_ge_sum = (SUM_W'(e_val) >= exp_sum);

  // Restoring division step
  assign rem2    = {rem, 1'b0};
  assign rem_ge  = (rem2 >= {1'b0, exp_sum});
  assign rem_sub = rem2 - {1'b0, exp_sum};

  // Position and argmax update
  assign count_adv     = (count < CNT_LAST) ? count + CNT_W'(1) : count;
  assign better        = (quot > top_prob);
  assign best_prob_sel = better ? quot : top_prob;
  assign best_idx_sel  = better ? idx_q : top_idx;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      swa_pkg::S_IDLE: begin
        if (in_fire) state_next = swa_pkg::S_MUL_Y;
      end
      swa_pkg::S_MUL_Y: begin
        if (mul_done) state_next = swa_pkg::S_MUL_P;
      end
      swa_pkg::S_MUL_P: begin
        if (mul_done) state_next = swa_pkg::S_MUL_PP;
      end
      swa_pkg::S_MUL_PP: begin
        if (mul_done) state_next = swa_pkg::S_MUL_MANT;
      end
      swa_pkg::S_MUL_MANT: begin
        if (mul_done) state_next = swa_pkg::S_APPLY;
      end
      swa_pkg::S_APPLY: begin
        if (!kind_q) state_next = swa_pkg::S_IDLE;
        else if (e_ge_sum) state_next = swa_pkg::S_FINISH;
        else state_next = swa_pkg::S_DIV;
      end
      swa_pkg::S_DIV: begin
        if (div_cnt == DIV_LAST) state_next = swa_pkg::S_FINISH;
      end
      swa_pkg::S_FINISH: begin
        if (out_free) state_next = swa_pkg::S_IDLE;
      end
      default: state_next = swa_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    sum_fire      = 1'b0;
    finish_fire   = 1'b0;
    case (state)
      swa_pkg::S_IDLE:   s_axis_tready = 1'b1;
      swa_pkg::S_APPLY:  sum_fire      = !kind_q;
      swa_pkg::S_FINISH: finish_fire   = out_free;
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

  // Control state: sequencer, sum, position, argmax, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= swa_pkg::S_IDLE;
      exp_sum   <= '0;
      count     <= '0;
      top_prob  <= '0;
      top_idx   <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // drop the result once taken, load a new one at the end of an item
      if (out_fire) out_valid <= 1'b0;
      if (finish_fire) out_valid <= 1'b1;
      // accumulate pass item
      if (sum_fire) begin
        exp_sum <= sum_sat;
        if (last_q) begin
          count    <= '0;
          top_prob <= '0;
          top_idx  <= '0;
        end else begin
          count <= count_adv;
        end
      end
      // normalize pass item
      if (finish_fire) begin
        if (last_q) begin
          exp_sum  <= '0;
          count    <= '0;
          top_prob <= '0;
          top_idx  <= '0;
        end else begin
          count    <= count_adv;
          top_prob <= best_prob_sel;
          top_idx  <= best_idx_sel;
        end
      end
    end
  end

  // Datapath: serial multiplier, exp stages, divider
  always_ff @(posedge clk) begin
    case (state)
      swa_pkg::S_IDLE: begin
        // capture the beat and start y = logit * log2(e)
        if (in_fire) begin
          kind_q <= s_axis_tuser;
          last_q <= s_axis_tlast;
          idx_q  <= count;
          acc    <= '0;
          mcand  <= {{(ACC_W - LOGIT_W){s_axis_tdata[LOGIT_W-1]}},
                     s_axis_tdata[LOGIT_W-1:0]};
          mplier <= MPL_W'(swa_pkg::LOG2E_Q16);
        end
      end
      swa_pkg::S_MUL_Y, swa_pkg::S_MUL_P, swa_pkg::S_MUL_PP,
      swa_pkg::S_MUL_MANT: begin
        if (!mul_done) begin
          // one multiplier bit per cycle
          acc    <= acc + (mplier[0] ? mcand : '0);
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
        end else begin
          acc <= '0;
          case (state)
            swa_pkg::S_MUL_Y: begin
              // split into integer and fraction, start r * ln2
              ushift <= u_val[29:24];
              frac_k <= u_val[23:20];
              mcand  <= ACC_W'(swa_pkg::LN2_Q24);
              mplier <= MPL_W'(u_val[19:0]);
            end
            swa_pkg::S_MUL_P: begin
              // start p * p
              p_val  <= acc[43:24];
              mcand  <= ACC_W'(acc[43:24]);
              mplier <= MPL_W'(acc[43:24]);
            end
            swa_pkg::S_MUL_PP: begin
              // start table * series
              mcand  <= ACC_W'(m_val);
              mplier <= MPL_W'(swa_pkg::pow2_frac(frac_k));
            end
            default: begin
              e_val <= e_calc;
            end
          endcase
        end
      end
      swa_pkg::S_APPLY: begin
        // set up the divider, or saturate when exp is not below the sum
        rem     <= SUM_W'(e_val);
        div_cnt <= '0;
        quot    <= e_ge_sum ? '1 : '0;
      end
      swa_pkg::S_DIV: begin
        rem     <= rem_ge ? rem_sub[SUM_W-1:0] : rem2[SUM_W-1:0];
        quot    <= {quot[PROB_W-2:0], rem_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      default: begin
        div_cnt <= div_cnt;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (finish_fire) begin
      out_prob      <= quot;
      out_idx       <= IDX_W'(idx_q);
      out_last      <= last_q;
      out_best_idx  <= IDX_W'(best_idx_sel);
      out_best_prob <= best_prob_sel;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tlast  = out_last;
  assign m_axis_tdata  = {4'b0, out_best_prob, out_best_idx, out_idx, out_prob};

  // Divider remainder stays below the sum
  assert property (@(posedge clk) disable iff (rst)
    (state == swa_pkg::S_DIV) |-> (rem < exp_sum))
    else $error("divider remainder not below sum");

  // Reported best probability is never below the item's own probability
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_best_prob >= out_prob))
    else $error("best probability below item probability");

  // Best index never lies past the item's own position
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_best_idx <= out_idx))
    else $error("best index past item index");

endmodule

// ----- tb/sv/softmax_with_argmax_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// softmax_with_argmax_tb
// Self-checking bench for the two-pass softmax with running argmax.
// ----------------------------------------------------------------------------
// Logit vectors are sent as an accumulate pass followed by a normalize pass.
// A bit-exact fixed-point softmax predictor runs on every accepted input beat
// and queues any result beat it expects. Every result beat is checked field by
// field against the oldest queued one. Both sides idle at random, the receiver
// holds off for a long stretch once, and the sum is driven into saturation.
// ----------------------------------------------------------------------------
module softmax_with_argmax_tb;
  localparam int LOGIT_W     = swa_pkg::LOGIT_W;
  localparam int PROB_W      = swa_pkg::PROB_W;
  localparam int IDX_W       = swa_pkg::IDX_W;
  localparam int SUM_W       = swa_pkg::SUM_W;
  localparam int E_W         = swa_pkg::E_W;
  localparam int MAX_CLASSES = swa_pkg::MAX_CLASSES;

  localparam logic KIND_ACCUM = 1'b0;
  localparam logic KIND_NORM  = 1'b1;

  localparam logic [SUM_W-1:0]          SUM_MAX   = '1;
  localparam logic signed [LOGIT_W-1:0] LOGIT_MIN = 13'h1000;
  localparam logic signed [LOGIT_W-1:0] LOGIT_MAX = 13'h0FFF;

  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int SAT_ITEMS    = 1960;
  localparam int RANDOM_ITEMS = 100;
  localparam longint CYCLE_LIMIT = 2_000_000;

  typedef struct packed {
    logic [PROB_W-1:0] prob;
    logic [IDX_W-1:0]  pos;
    logic              last;
    logic [IDX_W-1:0]  best_pos;
    logic [PROB_W-1:0] best_prob;
  } prob_beat_t;

  // 2^(k/16) in Q.16
  logic [16:0] frac_pow2 [16] = '{
    17'd65536, 17'd68438, 17'd71468, 17'd74632, 17'd77936, 17'd81386,
    17'd84990, 17'd88752, 17'd92682, 17'd96785, 17'd101070, 17'd105545,
    17'd110218, 17'd115098, 17'd120194, 17'd125515
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  // predictor state
  logic [SUM_W-1:0]  exp_total = '0;
  logic [IDX_W-1:0]  class_pos = '0;
  logic [PROB_W-1:0] peak_prob = '0;
  logic [IDX_W-1:0]  peak_pos  = '0;
  prob_beat_t        prob_queue [$];

  logic signed [LOGIT_W-1:0] logit_vec [$];

  int          src_gap_max    = 0;
  int          sink_stall_max = 0;
  int unsigned hold_req_n     = 0;
  int unsigned hold_ack_n     = 0;
  int          hold_left      = 0;
  int          stall_left     = 0;
  int          fail_count     = 0;
  int          sent_count     = 0;
  int          beat_count     = 0;
  longint      cycle_count    = 0;

  softmax_with_argmax #(.MAX_CLASSES(MAX_CLASSES)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // exp(x) in unsigned Q.16 through 2^(x*log2 e) with range reduction
  function automatic logic [E_W-1:0] exp_q16(input logic signed [LOGIT_W-1:0] x);
    longint      y;
    longint      u;
    int          n;
    int          sh;
    logic [3:0]  k;
    logic [63:0] f, r, p, m, mant, e;
    y = longint'(x) * 64'sd94548;
    u = y + (64'sd32 <<< 24);
    n = int'(u >>> 24) - 32;
    f = 64'(u) & 64'hFF_FFFF;
    k = f[23:20];
    r = f & 64'hF_FFFF;
    p = (r * 64'd11629080) >> 24;
    m = (64'd1 << 24) + p + ((p * p) >> 25);
    mant = (64'(frac_pow2[k]) * m) >> 8;
    sh = 16 - n;
    if (sh > 0) e = mant >> sh;
    else e = mant << (-sh);
    if (e == 0) e = 64'd1;
    return e[E_W-1:0];
  endfunction

  // advance the softmax state by one input beat, queue the result it gives
  task automatic softmax_step(input logic kind_i, input logic signed [LOGIT_W-1:0] x,
                              input logic last_i);
    logic [E_W-1:0]    e;
    logic [IDX_W-1:0]  here;
    logic [63:0]       quo;
    logic [PROB_W-1:0] prob;
    prob_beat_t        beat;
    e = exp_q16(x);
    here = class_pos;
    if (int'(class_pos) < MAX_CLASSES - 1) class_pos = class_pos + 1'b1;
    if (kind_i == KIND_ACCUM) begin
      if (exp_total > SUM_MAX - e) exp_total = SUM_MAX;
      else exp_total = exp_total + e;
      if (last_i) begin
        class_pos = '0;
        peak_prob = '0;
        peak_pos  = '0;
      end
    end else begin
      if (exp_total == '0) begin
        prob = '1;
      end else begin
        quo = {e, 16'h0000} / exp_total;
        prob = (quo > 64'd65535) ? '1 : quo[PROB_W-1:0];
      end
      // first position of the largest value wins ties
      if (prob > peak_prob) begin
        peak_prob = prob;
        peak_pos  = here;
      end
      beat = '{prob, here, last_i, peak_pos, peak_prob};
      prob_queue = {prob_queue, beat};
      if (last_i) begin
        exp_total = '0;
        class_pos = '0;
        peak_prob = '0;
        peak_pos  = '0;
      end
    end
  endtask

  task automatic check_beat();
    prob_beat_t want;
    prob_beat_t got;
    got = '{m_axis_tdata[15:0], m_axis_tdata[25:16], m_axis_tlast,
            m_axis_tdata[35:26], m_axis_tdata[51:36]};
    if (prob_queue.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d arrived with nothing expected: tdata %h last %b",
                 beat_count, m_axis_tdata, m_axis_tlast);
    end else begin
      want = prob_queue.pop_front();
      if (got !== want) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("result %0d mismatch (prob idx last best_idx best_prob):", beat_count);
          $display("  expected %0d %0d %0b %0d %0d", want.prob, want.pos, want.last,
                   want.best_pos, want.best_prob);
          $display("  actual   %0d %0d %0b %0d %0d", got.prob, got.pos, got.last,
                   got.best_pos, got.best_prob);
        end
      end
    end
    beat_count++;
  endtask

  // predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready)
        softmax_step(s_axis_tuser, s_axis_tdata[LOGIT_W-1:0], s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_beat();
    end
  end

  // receiver: long hold on request, else a random stall after each beat
  always @(posedge clk) begin
    if (hold_req_n != hold_ack_n) begin
      hold_ack_n = hold_req_n;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall_left = $urandom_range(0, sink_stall_max);
      m_axis_tready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= (stall_left == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, prob_queue.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one beat after a random gap; hold valid until it is taken
  task automatic send_logit(input logic kind_i, input logic signed [LOGIT_W-1:0] x,
                            input logic last_i);
    int gap;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, x};
    s_axis_tuser  <= kind_i;
    s_axis_tlast  <= last_i;
    do @(posedge clk); while (!s_axis_tready);
    sent_count++;
  endtask

  task automatic send_pass(input logic kind_i);
    foreach (logit_vec[i]) send_logit(kind_i, logit_vec[i], i == logit_vec.size() - 1);
  endtask

  // stop offering and hold until every expected result has come
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (prob_queue.size() != 0) @(posedge clk);
  endtask

  function automatic logic signed [LOGIT_W-1:0] draw_logit(
      input logic signed [LOGIT_W-1:0] center);
    case ($urandom_range(0, 9))
      0:       return LOGIT_MIN;
      1:       return LOGIT_MAX;
      2, 3, 4: return center + 13'($urandom_range(0, 255)) - 13'sd128;
      default: return 13'($urandom);
    endcase
  endfunction

  // random vector; clustered values and repeats to exercise the argmax
  task automatic fill_vector(input int len);
    logic signed [LOGIT_W-1:0] center;
    logic signed [LOGIT_W-1:0] pick;
    center = 13'($urandom);
    logit_vec.delete();
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(0, 7) == 0) pick = logit_vec[i-1];
      else pick = draw_logit(center);
      logit_vec = {logit_vec, pick};
    end
  endtask

  task automatic pick_idling();
    case ($urandom_range(0, 3))
      0:       src_gap_max = 0;
      1:       src_gap_max = 3;
      default: src_gap_max = 16;
    endcase
    case ($urandom_range(0, 3))
      0:       sink_stall_max <= 0;
      1:       sink_stall_max <= 3;
      default: sink_stall_max <= 16;
    endcase
  endtask

  task automatic test_directed();
    src_gap_max = 2;
    sink_stall_max <= 2;
    // normalize with nothing accumulated
    send_logit(KIND_NORM, 13'sd0, 1'b1);
    // field extremes
    logit_vec = {LOGIT_MIN, LOGIT_MAX, 13'sd0, -13'sd1, 13'sd1};
    send_pass(KIND_ACCUM);
    send_pass(KIND_NORM);
    // logit far above the accumulated ones: probability saturates
    send_logit(KIND_ACCUM, LOGIT_MIN, 1'b1);
    send_logit(KIND_NORM, LOGIT_MAX, 1'b0);
    send_logit(KIND_NORM, LOGIT_MIN, 1'b1);
    // passes interleaved; accumulate end clears position and argmax
    send_logit(KIND_ACCUM, 13'sd100, 1'b0);
    send_logit(KIND_NORM, 13'sd100, 1'b0);
    send_logit(KIND_ACCUM, -13'sd50, 1'b1);
    send_logit(KIND_NORM, -13'sd50, 1'b1);
    // equal probabilities: first index stays best
    logit_vec = {13'sd256, 13'sd256};
    send_pass(KIND_ACCUM);
    send_pass(KIND_NORM);
    wait_drained();
  endtask

  task automatic test_backpressure();
    src_gap_max = 0;
    sink_stall_max <= 0;
    fill_vector(24);
    send_pass(KIND_ACCUM);
    // receiver stops while the normalize pass keeps coming
    hold_req_n <= hold_req_n + 1;
    send_pass(KIND_NORM);
    wait_drained();
  endtask

  task automatic test_sum_saturation();
    src_gap_max = 0;
    sink_stall_max <= 2;
    // enough maximal terms to pin the sum and the position counter
    for (int i = 0; i < SAT_ITEMS; i++) send_logit(KIND_ACCUM, LOGIT_MAX, 1'b0);
    send_logit(KIND_NORM, LOGIT_MAX, 1'b0);
    send_logit(KIND_NORM, 13'sd0, 1'b0);
    send_logit(KIND_NORM, LOGIT_MIN, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_vectors();
    int stop_at;
    int len;
    int shape;
    stop_at = sent_count + RANDOM_ITEMS;
    while (sent_count < stop_at) begin
      pick_idling();
      shape = $urandom_range(0, 19);
      len = (shape == 4) ? $urandom_range(30, 60) : $urandom_range(1, 12);
      fill_vector(len);
      case (shape)
        // normalize pass with no accumulate pass of its own
        0: send_pass(KIND_NORM);
        // unterminated accumulate run, then a full vector
        1: begin
          foreach (logit_vec[i]) send_logit(KIND_ACCUM, logit_vec[i], 1'b0);
          send_pass(KIND_ACCUM);
          send_pass(KIND_NORM);
        end
        // normalize logits that differ from the accumulated ones
        2: begin
          send_pass(KIND_ACCUM);
          fill_vector(len);
          send_pass(KIND_NORM);
        end
        // noise: random kinds and random ends
        3: begin
          for (int i = 0; i < len; i++)
            send_logit(1'($urandom_range(0, 1)), draw_logit(13'sd0),
                       $urandom_range(0, 3) == 0);
        end
        default: begin
          send_pass(KIND_ACCUM);
          send_pass(KIND_NORM);
        end
      endcase
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_sum_saturation();
    test_random_vectors();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (prob_queue.size() != 0) begin
      $display("%0d expected results never arrived", prob_queue.size());
      fail_count += prob_queue.size();
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
